// ===== design/assert_macros.svh =====
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`endif

// ===== design/tsdtw_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package tsdtw_pkg;
    localparam int MaxLenDef = 16;
    localparam int SampleBitsDef = 16;
    localparam int LenW = 5;
    localparam int PosW = 4;
    localparam int SampW = 16;
    localparam int DistW = 32;
    localparam logic [DistW-1:0] Sat = '1;

    typedef enum logic [1:0] {
        REQ_LOAD_A = 2'd0,
        REQ_LOAD_B = 2'd1,
        REQ_LOAD_C = 2'd2,
        REQ_RUN    = 2'd3
    } req_t;

    localparam logic [1:0] CFG_LEN_A = 2'd0;
    localparam logic [1:0] CFG_LEN_B = 2'd1;
    localparam logic [1:0] CFG_LEN_C = 2'd2;

    typedef struct packed {
        logic init;      // reset counters for a run
        logic fill_step; // advance fill sequencer
        logic trace_step;
        logic emit_step;
    } tsdtw_cmd_t;

    typedef struct packed {
        logic fill_done;
        logic trace_done;
        logic emit_last;
    } tsdtw_sts_t;
endpackage
`default_nettype wire

// ===== design/tsdtw_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface tsdtw_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [3:0]  position;
    logic signed [15:0] sample;
    modport source (output valid, req_type, position, sample, input ready);
    modport sink (input valid, req_type, position, sample, output ready);
endinterface
`default_nettype wire

// ===== design/tsdtw_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface tsdtw_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] distance;
    logic [4:0]  pos_a;
    logic [4:0]  pos_b;
    logic [4:0]  pos_c;
    logic        last_step;
    modport source (output valid, distance, pos_a, pos_b, pos_c, last_step, input ready);
    modport sink (input valid, distance, pos_a, pos_b, pos_c, last_step, output ready);
endinterface
`default_nettype wire

// ===== design/tsdtw_cfg_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface tsdtw_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [4:0]  data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== design/tsdtw_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tsdtw_ctrl
    import tsdtw_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       run_start,
    input  wire logic       out_ready,
    input  wire tsdtw_sts_t sts,
    output tsdtw_cmd_t      cmd,
    output logic            idle,
    output logic            out_valid
);
    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_INIT  = 5'b00010,
        S_FILL  = 5'b00100,
        S_TRACE = 5'b01000,
        S_EMIT  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (run_start)
                    state_next = S_INIT;
            end
            S_INIT:
            begin
                cmd.init = 1'b1;
                state_next = S_FILL;
            end
            S_FILL:
            begin
                cmd.fill_step = 1'b1;
                if (sts.fill_done)
                    state_next = S_TRACE;
            end
            S_TRACE:
            begin
                cmd.trace_step = 1'b1;
                if (sts.trace_done)
                    state_next = S_EMIT;
            end
            S_EMIT:
            begin
                cmd.emit_step = out_ready;
                if (out_ready && sts.emit_last)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign idle = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_EMIT);
endmodule
`default_nettype wire

// ===== design/tsdtw_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tsdtw_dp
    import tsdtw_pkg::*;
#(
    parameter int MAX_LEN = MaxLenDef,
    parameter int SAMPLE_BITS = SampleBitsDef
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             load_en,
    input  wire logic [1:0]       load_sel,
    input  wire logic [PosW-1:0]  load_pos,
    input  wire logic [SampW-1:0] load_sample,
    input  wire logic [LenW-1:0]  len_a,
    input  wire logic [LenW-1:0]  len_b,
    input  wire logic [LenW-1:0]  len_c,
    input  wire tsdtw_cmd_t       cmd,
    output tsdtw_sts_t            sts,
    output logic [DistW-1:0]      distance,
    output logic [LenW-1:0]       pos_a,
    output logic [LenW-1:0]       pos_b,
    output logic [LenW-1:0]       pos_c,
    output logic                  last_step
);
    localparam int Side = MAX_LEN + 1;
    localparam int IW = $clog2(Side);
    localparam int SIW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int Cube = Side * Side * Side;
    localparam int CW = $clog2(Cube);
    localparam int Inner = MAX_LEN * MAX_LEN * MAX_LEN;
    localparam int BW = (Inner > 1) ? $clog2(Inner) : 1;
    localparam int PathMax = 3 * MAX_LEN + 1;
    localparam int PW = $clog2(PathMax + 1);
    localparam int DW = SAMPLE_BITS + 2;

    typedef enum logic [3:0] {
        F_CLEAR, F_SET, F_RD0, F_RD1, F_RD2, F_RD3, F_RD4, F_RD5, F_RD6, F_WAIT, F_WR, F_DONE
    } fph_t;

    logic [SAMPLE_BITS-1:0] mem_a [MAX_LEN];
    logic [SAMPLE_BITS-1:0] mem_b [MAX_LEN];
    logic [SAMPLE_BITS-1:0] mem_c [MAX_LEN];
    logic [DistW-1:0] cube_mem [Cube];
    logic [2:0] dir_mem [Inner];
    logic [3*LenW-1:0] path_mem [PathMax];

    always_ff @(posedge clk)
    begin
        if (load_en && (32'(load_pos) < MAX_LEN))
        begin
            case (load_sel)
                REQ_LOAD_A: mem_a[SIW'(load_pos)] <= SAMPLE_BITS'(load_sample);
                REQ_LOAD_B: mem_b[SIW'(load_pos)] <= SAMPLE_BITS'(load_sample);
                default:    mem_c[SIW'(load_pos)] <= SAMPLE_BITS'(load_sample);
            endcase
        end
    end

    function automatic logic [IW-1:0] clamp(input logic [LenW-1:0] v);
        logic [IW-1:0] r;
        if (v == '0)
            r = IW'(1);
        else if (32'(v) > MAX_LEN)
            r = IW'(MAX_LEN);
        else
            r = IW'(v);
        return r;
    endfunction

    function automatic logic [CW-1:0] cix(input logic [IW-1:0] i, input logic [IW-1:0] j,
                                          input logic [IW-1:0] k);
        return CW'((32'(i) * Side + 32'(j)) * Side + 32'(k));
    endfunction

    function automatic logic [BW-1:0] bix(input logic [IW-1:0] i, input logic [IW-1:0] j,
                                          input logic [IW-1:0] k);
        return BW'((32'(i - 1'b1) * MAX_LEN + 32'(j - 1'b1)) * MAX_LEN + 32'(k - 1'b1));
    endfunction

    logic [IW-1:0] na_reg, nb_reg, nc_reg;
    logic [IW-1:0] i_reg, j_reg, k_reg;
    logic [CW-1:0] clr_reg;
    fph_t ph_reg;
    logic [DistW-1:0] best_reg, rd_reg;
    logic [2:0] dir_reg, rdir_reg;
    logic [2:0] rsel_reg;
    logic found_reg;
    logic [DistW-1:0] cost_reg;
    logic [DistW-1:0] dist_reg;
    logic [PW-1:0] cnt_reg, emit_reg;
    logic [2:0] bd_dir;
    logic tr_ph_reg, tr_done_reg;
    logic [3*LenW-1:0] pcell_reg;
    logic [PW-1:0] prd_addr;

    // neighbour order
    function automatic logic [2:0] ord(input logic [2:0] t);
        logic [2:0] d;
        case (t)
            3'd0: d = 3'd4;
            3'd1: d = 3'd2;
            3'd2: d = 3'd1;
            3'd3: d = 3'd6;
            3'd4: d = 3'd5;
            3'd5: d = 3'd3;
            default: d = 3'd7;
        endcase
        return d;
    endfunction

    logic [2:0] cur_d;
    logic [CW-1:0] rd_addr;
    logic signed [DW-1:0] diff;
    logic [DW-1:0] mag;
    logic [DistW:0] sum;
    logic [DistW-1:0] new_cost;
    logic cube_we;
    logic [CW-1:0] cube_wa;
    logic [DistW-1:0] cube_wd;

    assign cur_d = ord(3'(ph_reg - F_RD0));
    assign rd_addr = cix(i_reg - IW'(cur_d[2]), j_reg - IW'(cur_d[1]), k_reg - IW'(cur_d[0]));
    assign diff = DW'($signed(mem_a[i_reg[SIW-1:0] - 1'b1]))
                - DW'($signed(mem_b[j_reg[SIW-1:0] - 1'b1]))
                - DW'($signed(mem_c[k_reg[SIW-1:0] - 1'b1]));
    assign mag = diff[DW-1] ? DW'(-diff) : DW'(diff);
    assign sum = {1'b0, cost_reg} + {1'b0, best_reg};
    assign new_cost = sum[DistW] ? Sat : sum[DistW-1:0];

    // next path entry to present, read ahead into pcell_reg
    assign prd_addr = cmd.emit_step ? emit_reg - 1'b1 : emit_reg;

    always_comb
    begin
        cube_we = 1'b0;
        cube_wa = clr_reg;
        cube_wd = Sat;
        if (cmd.fill_step && ph_reg == F_CLEAR)
            cube_we = 1'b1;
        else if (cmd.fill_step && ph_reg == F_SET)
        begin
            cube_we = 1'b1;
            cube_wa = '0;
            cube_wd = '0;
        end
        else if (cmd.fill_step && ph_reg == F_WR)
        begin
            cube_we = 1'b1;
            cube_wa = cix(i_reg, j_reg, k_reg);
            cube_wd = new_cost;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cube_we)
            cube_mem[cube_wa] <= cube_wd;
        rd_reg <= cube_mem[(ph_reg == F_DONE) ? cix(na_reg, nb_reg, nc_reg) : rd_addr];
        rdir_reg <= dir_mem[bix(i_reg, j_reg, k_reg)];
        if (cmd.fill_step && ph_reg == F_WR)
            dir_mem[bix(i_reg, j_reg, k_reg)] <= dir_reg;
        if (cmd.trace_step && !tr_ph_reg && !tr_done_reg)
            path_mem[cnt_reg[PW-1:0]] <= {LenW'(i_reg), LenW'(j_reg), LenW'(k_reg)};
        pcell_reg <= path_mem[prd_addr];
    end

    // fill sequencer: clear sweep, origin, then 7 neighbour reads per cell
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg <= F_CLEAR;
            clr_reg <= '0;
            i_reg <= '0;
            j_reg <= '0;
            k_reg <= '0;
            cnt_reg <= '0;
            emit_reg <= '0;
            tr_ph_reg <= 1'b0;
            tr_done_reg <= 1'b0;
            found_reg <= 1'b0;
        end
        else if (cmd.init)
        begin
            na_reg <= clamp(len_a);
            nb_reg <= clamp(len_b);
            nc_reg <= clamp(len_c);
            ph_reg <= F_CLEAR;
            clr_reg <= '0;
            i_reg <= IW'(1);
            j_reg <= IW'(1);
            k_reg <= IW'(1);
            cnt_reg <= '0;
            tr_ph_reg <= 1'b0;
            tr_done_reg <= 1'b0;
        end
        else if (cmd.fill_step)
        begin
            case (ph_reg)
                F_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (32'(clr_reg) == Cube - 1)
                        ph_reg <= F_SET;
                end
                F_SET: ph_reg <= F_RD0;
                F_RD0:
                begin
                    cost_reg <= (32'(mag) > 32'hFFFF_FFFF) ? Sat : DistW'(mag);
                    found_reg <= 1'b0;
                    rsel_reg <= cur_d;
                    ph_reg <= F_RD1;
                end
                F_RD1, F_RD2, F_RD3, F_RD4, F_RD5, F_RD6, F_WAIT:
                begin
                    if (!found_reg || rd_reg < best_reg)
                    begin
                        best_reg <= rd_reg;
                        dir_reg <= rsel_reg;
                    end
                    found_reg <= 1'b1;
                    rsel_reg <= cur_d;
                    ph_reg <= fph_t'(ph_reg + 1'b1);
                end
                F_WR:
                begin
                    ph_reg <= F_RD0;
                    if (k_reg != nc_reg)
                        k_reg <= k_reg + 1'b1;
                    else
                    begin
                        k_reg <= IW'(1);
                        if (j_reg != nb_reg)
                            j_reg <= j_reg + 1'b1;
                        else
                        begin
                            j_reg <= IW'(1);
                            if (i_reg != na_reg)
                                i_reg <= i_reg + 1'b1;
                            else
                            begin
                                i_reg <= na_reg;
                                j_reg <= nb_reg;
                                k_reg <= nc_reg;
                                ph_reg <= F_DONE;
                            end
                        end
                    end
                end
                default: ph_reg <= F_DONE;
            endcase
        end
        else if (cmd.trace_step)
        begin
            if (!tr_ph_reg)
            begin
                // rd_reg now holds the end cell cost
                if (cnt_reg == '0 && !tr_done_reg)
                    dist_reg <= rd_reg;
                if ((i_reg | j_reg | k_reg) == '0 || 32'(cnt_reg) == PathMax - 1)
                begin
                    tr_done_reg <= 1'b1;
                    emit_reg <= cnt_reg;
                end
                else
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    tr_ph_reg <= 1'b1;
                end
            end
            else
            begin
                tr_ph_reg <= 1'b0;
                if (bd_dir[2]) i_reg <= i_reg - 1'b1;
                if (bd_dir[1]) j_reg <= j_reg - 1'b1;
                if (bd_dir[0]) k_reg <= k_reg - 1'b1;
            end
        end
        else if (cmd.emit_step)
        begin
            emit_reg <= emit_reg - 1'b1;
        end
    end

    assign bd_dir = (i_reg != '0 && j_reg != '0 && k_reg != '0) ? rdir_reg :
                    {i_reg != '0, j_reg != '0, k_reg != '0};

    // origin entry stands at emit index equal to final count
    logic [3*LenW-1:0] pcell;
    assign pcell = (emit_reg == cnt_reg) ? '0 : pcell_reg;

    assign sts.fill_done = (ph_reg == F_DONE);
    assign sts.trace_done = tr_done_reg;
    assign sts.emit_last = (emit_reg == '0);
    assign distance = dist_reg;
    assign pos_a = pcell[3*LenW-1:2*LenW];
    assign pos_b = pcell[2*LenW-1:LenW];
    assign pos_c = pcell[LenW-1:0];
    assign last_step = (emit_reg == '0);
endmodule
`default_nettype wire

// ===== design/three_sequence_dtw_with_path.sv =====
// sequence: a run clears the (MAX_LEN+1)^3 cost cube, fills each inner cell from its
// neighbour reads, a wait and a write, then traces the path back before the first result
// results follow one per cycle while the sink is ready
// throughput: one load per cycle; one run at a time, no input taken during a run
// reset: rst_n asynchronous active low; lengths return to 16, samples undefined
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module three_sequence_dtw_with_path
    import tsdtw_pkg::*;
#(
    parameter int MAX_LEN = MaxLenDef,
    parameter int SAMPLE_BITS = SampleBitsDef
)
(
    input wire logic    clk,
    input wire logic    rst_n,
    tsdtw_in_if.sink    in_ch,
    tsdtw_cfg_if.sink   cfg,
    tsdtw_out_if.source out_ch
);
    logic [LenW-1:0] len_a_reg, len_b_reg, len_c_reg;
    tsdtw_cmd_t cmd;
    tsdtw_sts_t sts;
    logic idle, in_xfer;

    assign cfg.ready = 1'b1;
    assign in_ch.ready = idle;
    assign in_xfer = in_ch.valid && in_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_a_reg <= LenW'(16);
            len_b_reg <= LenW'(16);
            len_c_reg <= LenW'(16);
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_LEN_A: len_a_reg <= cfg.data;
                CFG_LEN_B: len_b_reg <= cfg.data;
                CFG_LEN_C: len_c_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    tsdtw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .run_start (in_xfer && in_ch.req_type == REQ_RUN),
        .out_ready (out_ch.ready),
        .sts       (sts),
        .cmd       (cmd),
        .idle      (idle),
        .out_valid (out_ch.valid)
    );

    tsdtw_dp #(.MAX_LEN(MAX_LEN), .SAMPLE_BITS(SAMPLE_BITS)) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .load_en     (in_xfer && in_ch.req_type != REQ_RUN),
        .load_sel    (in_ch.req_type),
        .load_pos    (in_ch.position),
        .load_sample (in_ch.sample),
        .len_a       (len_a_reg),
        .len_b       (len_b_reg),
        .len_c       (len_c_reg),
        .cmd         (cmd),
        .sts         (sts),
        .distance    (out_ch.distance),
        .pos_a       (out_ch.pos_a),
        .pos_b       (out_ch.pos_b),
        .pos_c       (out_ch.pos_c),
        .last_step   (out_ch.last_step)
    );

    `ASSERT_NEVER(a_no_take_busy, in_ch.ready && out_ch.valid, "input taken while emitting")
    `ASSERT_CLK(a_one_cmd, $onehot0({cmd.init, cmd.fill_step, cmd.trace_step, cmd.emit_step}),
        "overlapping commands")
    `ASSERT_CLK(a_last_idle, (out_ch.valid && out_ch.ready && out_ch.last_step) |=> idle,
        "no idle after last transfer")
endmodule
`default_nettype wire
